/* design/rr_pkg.sv */
// Shared types and constants for the rectangle rasterizer.
package rr_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CANVAS_WIDTH  = 2'd0,
		REG_CANVAS_HEIGHT = 2'd1,
		REG_BACKGROUND    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SWEEP,
		ST_READ,
		ST_DONE
	} state_t;

	localparam logic [7:0] SHAPE_FILLED  = 8'h52;
	localparam logic [7:0] SHAPE_OUTLINE = 8'h72;
	localparam int         FRAC_BITS     = 8;
	localparam int         ONE_UNIT      = 256;
	localparam int         COORD_W       = 18;
	localparam int         CFG_DATA_W    = 9;
	localparam logic [8:0] CFG_W_RESET   = 9'd1;
	localparam logic [8:0] CFG_H_RESET   = 9'd1;
	localparam logic [7:0] CFG_BG_RESET  = 8'd32;

endpackage

/* design/rr_in_if.sv */
// Input item channel of the rectangle rasterizer.
interface rr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [7:0]         shape_code;
	logic signed [17:0] rect_left;
	logic signed [17:0] rect_top;
	logic signed [17:0] rect_width;
	logic signed [17:0] rect_height;
	logic [7:0]         paint_char;
	logic [7:0]         pixel_x;
	logic [7:0]         pixel_y;

	modport source (
		output valid, operation, shape_code, rect_left, rect_top, rect_width,
			rect_height, paint_char, pixel_x, pixel_y,
		input  ready
	);
	modport sink (
		input  valid, operation, shape_code, rect_left, rect_top, rect_width,
			rect_height, paint_char, pixel_x, pixel_y,
		output ready
	);
endinterface

/* design/rr_out_if.sv */
// Result channel of the rectangle rasterizer.
interface rr_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] pixel_value;

	modport source (output valid, status, pixel_value, input ready);
	modport sink (input valid, status, pixel_value, output ready);
endinterface

/* design/rr_cfg_if.sv */
// Configuration write channel of the rectangle rasterizer.
interface rr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/rr_ram.sv */
// Generic single-port RAM with registered read data.
module rr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

/* design/rectangle_rasterizer_core.sv */
// Top level of the rectangle rasterizer: control sequencer around the canvas RAM.
// Usage:
//   cfg    : register writes (0 width, 1 height, 2 background); always ready,
//            write only while the block is idle.
//   item   : one operation per transaction (clear, draw, read, no-op); ready
//            only while the sequencer is idle, so one item is in work at a time.
//   result : one transaction per item carrying status and pixel_value.
// Steps, with cw/ch the canvas size in use (clamped to 1..MAX_SIDE):
//   clear : sweep over all cw*ch pixels, one pixel written per cycle
//   draw  : a setup state computes the edge bounds, then the cw*ch sweep
//   read  : one RAM read with registered data
//   rejected draw, no-op, read outside the canvas : straight to the done state
// The single write port of the canvas RAM sets the sweep rate of one pixel
// per cycle. The result sits in an output register; a new item is taken
// while it waits, and a finished item holds in the done state until the
// register frees up. Reset returns the sequencer to idle, drops any pending
// result and restores the register defaults; canvas contents are undefined
// until the first clear.
module rectangle_rasterizer_core #(
	parameter int MAX_SIDE = 256
) (
	input logic    clk,
	input logic    arst_n,
	rr_in_if.sink  item,
	rr_out_if.source result,
	rr_cfg_if.sink cfg
);
	import rr_pkg::*;

	localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CW    = $clog2(MAX_SIDE + 1);
	localparam int SW    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int AW    = 2 * XW;
	localparam int DEPTH = 1 << AW;
	localparam int GW    = (((XW + FRAC_BITS + 1) > (COORD_W + 2)) ?
		(XW + FRAC_BITS + 1) : (COORD_W + 2)) + 1;

	state_t state_q, state_d;

	logic [8:0] cfg_w_q, cfg_h_q;
	logic [7:0] bg_q;

	op_t               op_q;
	logic              filled_q;
	logic [7:0]        paint_q;
	logic              reject_q;
	logic              hit_q;
	logic [XW-1:0]     rx_q, ry_q;
	logic signed [GW-1:0] l_q, t_q, w_q, h_q;
	logic signed [GW-1:0] r_q, b_q, l1_q, t1_q, r1_q, b1_q;
	logic [XW-1:0]     x_q, y_q;

	logic              out_valid_q;
	logic              status_q;
	logic [7:0]        pixel_q;

	logic [SW-1:0]     wext, hext;
	logic [CW-1:0]     cw, ch;
	logic              accept, slot_free, last_x, last_y, in_range;
	logic              in_rect, border, paint_hit;
	logic signed [GW-1:0] px, py;
	op_t               op_in;
	logic              bad_draw;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_wdata, ram_rdata;

	// Clamp the configured size to 1..MAX_SIDE.
	assign wext = SW'(cfg_w_q);
	assign hext = SW'(cfg_h_q);
	assign cw = (wext == '0) ? CW'(1) : ((wext > SW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(wext));
	assign ch = (hext == '0) ? CW'(1) : ((hext > SW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(hext));

	assign accept    = item.valid && item.ready;
	assign slot_free = !out_valid_q || result.ready;
	assign last_x    = (CW'(x_q) == cw - CW'(1));
	assign last_y    = (CW'(y_q) == ch - CW'(1));
	assign op_in     = op_t'(item.operation);
	assign in_range  = (SW'(item.pixel_x) < SW'(cw)) && (SW'(item.pixel_y) < SW'(ch));
	assign bad_draw  = item.rect_width[COORD_W-1] || (item.rect_width == '0) ||
		item.rect_height[COORD_W-1] || (item.rect_height == '0) ||
		((item.shape_code != SHAPE_FILLED) && (item.shape_code != SHAPE_OUTLINE));

	// Pixel test against the bounds prepared in the setup cycle.
	assign px = signed'(GW'({x_q, FRAC_BITS'(0)}));
	assign py = signed'(GW'({y_q, FRAC_BITS'(0)}));
	assign in_rect = (px >= l_q) && (px <= r_q) && (py >= t_q) && (py <= b_q);
	assign border = (px < l1_q) || (px > r1_q) || (py < t1_q) || (py > b1_q);
	assign paint_hit = in_rect && (filled_q || border);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_W_RESET;
			cfg_h_q <= CFG_H_RESET;
			bg_q    <= CFG_BG_RESET;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_CANVAS_WIDTH:  cfg_w_q <= cfg.data;
				REG_CANVAS_HEIGHT: cfg_h_q <= cfg.data;
				REG_BACKGROUND:    bg_q    <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_in)
						OP_CLEAR: state_d = ST_SWEEP;
						OP_DRAW:  state_d = bad_draw ? ST_DONE : ST_SETUP;
						OP_READ:  state_d = in_range ? ST_READ : ST_DONE;
						OP_NOP:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SETUP: state_d = ST_SWEEP;
			ST_SWEEP: if (last_x && last_y) state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_DONE:  if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item.ready = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = {y_q, x_q};
		ram_wdata  = (op_q == OP_CLEAR) ? bg_q : paint_q;
		unique case (state_q)
			ST_IDLE:  item.ready = 1'b1;
			ST_SWEEP: ram_we = (op_q == OP_CLEAR) || paint_hit;
			ST_READ: begin
				ram_re   = 1'b1;
				ram_addr = {ry_q, rx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_in;
			filled_q <= (item.shape_code == SHAPE_FILLED);
			paint_q  <= item.paint_char;
			reject_q <= (op_in == OP_DRAW) && bad_draw;
			hit_q    <= (op_in == OP_READ) && in_range;
			rx_q     <= XW'(item.pixel_x);
			ry_q     <= XW'(item.pixel_y);
			l_q      <= GW'(item.rect_left);
			t_q      <= GW'(item.rect_top);
			w_q      <= GW'(item.rect_width);
			h_q      <= GW'(item.rect_height);
			x_q      <= '0;
			y_q      <= '0;
		end
		if (state_q == ST_SETUP) begin
			r_q  <= l_q + w_q;
			b_q  <= t_q + h_q;
			l1_q <= l_q + GW'(ONE_UNIT);
			t1_q <= t_q + GW'(ONE_UNIT);
			r1_q <= l_q + w_q - GW'(ONE_UNIT);
			b1_q <= t_q + h_q - GW'(ONE_UNIT);
		end
		if (state_q == ST_SWEEP) begin
			if (last_x) begin
				x_q <= '0;
				y_q <= y_q + XW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
		if (state_q == ST_DONE && slot_free) begin
			status_q <= reject_q;
			pixel_q  <= hit_q ? ram_rdata : 8'd0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.status      = status_q;
	assign result.pixel_value = pixel_q;

	rr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_canvas (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);
endmodule
